/* rtl/keyframe_hermite_curve_eval_unit_defines.svh */
// assertion macros shared by the keyframe hermite curve evaluator
// no dependencies; included by modules that carry concurrent checks
`ifndef KEYFRAME_HERMITE_CURVE_EVAL_UNIT_DEFINES_SVH
`define KEYFRAME_HERMITE_CURVE_EVAL_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define KFH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define KFH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kfh_pkg.sv */
// types, constants and the arithmetic step table of the keyframe curve evaluator
// no dependencies; imported by kfh_dpath, kfh_ctrl and the top level
`default_nettype none

package kfh_pkg;

  localparam int unsigned KT_W = 16;
  localparam int unsigned KV_W = 32;
  localparam int unsigned KC_W = 6;
  localparam int unsigned STEP_W = 4;

  // result status codes
  localparam logic [1:0] STATUS_INTERP = 2'd0;
  localparam logic [1:0] STATUS_HELD   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  // last divider step and last arithmetic step
  localparam logic [STEP_W-1:0] DIV_LAST   = 4'd15;
  localparam logic [STEP_W-1:0] ARITH_LAST = 4'd12;

  // one stored keyframe
  typedef struct packed {
    logic [KT_W-1:0] key_time;
    logic [KV_W-1:0] value;
    logic [KV_W-1:0] in_slope;
    logic [KV_W-1:0] out_slope;
  } kfh_entry_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_UU,
    MUL_U2U,
    MUL_OUT0D,
    MUL_IN1D,
    MUL_H00V0,
    MUL_H01V1,
    MUL_H10M0L,
    MUL_H10M0H,
    MUL_H11M1L,
    MUL_H11M1H
  } mul_sel_e;

  // where the registered product goes
  typedef enum logic [2:0] {
    WB_NONE,
    WB_U2,
    WB_U3,
    WB_M0,
    WB_M1,
    WB_H,
    WB_ADD0,
    WB_ADD24
  } wb_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    wb_sel_e  wb_sel;
  } arith_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      scan_init;
    logic      scan_run;
    logic      div_init;
    logic      div_step;
    arith_op_t op;
    logic      res_ld;
  } kfh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic interp;
  } kfh_stat_t;

  // arithmetic schedule: multiply in one step, write back the product in the next
  function automatic arith_op_t arith_cmd(input logic [STEP_W-1:0] step);
    arith_op_t op;
    op = '{mul_sel: MUL_NONE, wb_sel: WB_NONE};
    case (step)
      4'd0:  op = '{mul_sel: MUL_UU,     wb_sel: WB_NONE};
      4'd1:  op = '{mul_sel: MUL_OUT0D,  wb_sel: WB_U2};
      4'd2:  op = '{mul_sel: MUL_IN1D,   wb_sel: WB_M0};
      4'd3:  op = '{mul_sel: MUL_U2U,    wb_sel: WB_M1};
      4'd4:  op = '{mul_sel: MUL_NONE,   wb_sel: WB_U3};
      4'd5:  op = '{mul_sel: MUL_NONE,   wb_sel: WB_H};
      4'd6:  op = '{mul_sel: MUL_H00V0,  wb_sel: WB_NONE};
      4'd7:  op = '{mul_sel: MUL_H01V1,  wb_sel: WB_ADD0};
      4'd8:  op = '{mul_sel: MUL_H10M0L, wb_sel: WB_ADD0};
      4'd9:  op = '{mul_sel: MUL_H10M0H, wb_sel: WB_ADD0};
      4'd10: op = '{mul_sel: MUL_H11M1L, wb_sel: WB_ADD24};
      4'd11: op = '{mul_sel: MUL_H11M1H, wb_sel: WB_ADD0};
      4'd12: op = '{mul_sel: MUL_NONE,   wb_sel: WB_ADD24};
      default: op = '{mul_sel: MUL_NONE, wb_sel: WB_NONE};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

/* rtl/kfh_ram.sv */
// generic single write port, single read port memory with registered read
// no dependencies
`default_nettype none

module kfh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/kfh_dpath.sv */
// datapath: key table, bracket search, radix-2 divider, shared multiplier, accumulator
// depends on kfh_pkg and kfh_ram
`default_nettype none

module kfh_dpath
  import kfh_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [KC_W-1:0]  cfg_data_i,
  input  wire logic [4:0]       key_index_i,
  input  wire logic [KT_W-1:0]  key_time_i,
  input  wire logic [KV_W-1:0]  key_value_i,
  input  wire logic [KV_W-1:0]  key_in_tangent_i,
  input  wire logic [KV_W-1:0]  key_out_tangent_i,
  input  wire logic [KT_W-1:0]  eval_time_i,
  input  wire kfh_cmd_t         cmd_i,
  output kfh_stat_t             stat_o,
  output logic      [KV_W-1:0]  curve_value_o,
  output logic      [1:0]       status_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned EW = $bits(kfh_entry_t);

  // configuration register
  logic [KC_W-1:0] key_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  // key table
  kfh_entry_t       wr_ent;
  kfh_entry_t       ent;
  logic [EW-1:0]    rdata;
  logic             wr_en;
  logic             rd_en;
  logic [CW-1:0]    rd_idx_q;

  assign wr_ent = '{key_time: key_time_i, value: key_value_i,
                    in_slope: key_in_tangent_i, out_slope: key_out_tangent_i};
  assign wr_en  = cmd_i.load && (32'(key_index_i) < MAX_KEYS);
  assign ent    = kfh_entry_t'(rdata);

  kfh_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_KEYS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AW'(key_index_i)),
    .wdata_i(EW'(wr_ent)),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // bracket search, one key per cycle
  logic [CW-1:0]   n_q;
  logic [KT_W-1:0] t_q;
  logic            chk_vld_q;
  logic            have_lo_q;
  logic            have_hi_q;
  logic            exact_q;
  logic [KT_W-1:0] lo_time_q;
  logic [KV_W-1:0] lo_val_q;
  logic [KV_W-1:0] lo_out_q;
  logic [KT_W-1:0] hi_time_q;
  logic [KV_W-1:0] hi_val_q;
  logic [KV_W-1:0] hi_in_q;
  logic [KV_W-1:0] last_val_q;
  logic            chk;
  logic            hit;
  logic [CW-1:0]   n_clamp;

  assign n_clamp = (32'(key_count_q) < MAX_KEYS) ? CW'(key_count_q) : CW'(MAX_KEYS);
  assign chk     = cmd_i.scan_run && chk_vld_q && !have_hi_q;
  assign hit     = chk && (ent.key_time >= t_q);
  assign rd_en   = cmd_i.scan_run && !have_hi_q && !hit && (rd_idx_q != n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      have_lo_q <= 1'b0;
      have_hi_q <= 1'b0;
      exact_q   <= 1'b0;
    end else if (cmd_i.scan_init) begin
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      have_lo_q <= 1'b0;
      have_hi_q <= 1'b0;
      exact_q   <= 1'b0;
    end else begin
      chk_vld_q <= rd_en;
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (chk && (ent.key_time <= t_q)) begin
        have_lo_q <= 1'b1;
      end
      if (hit) begin
        have_hi_q <= 1'b1;
        exact_q   <= (ent.key_time == t_q);
      end
    end
  end

  // search payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      n_q <= n_clamp;
      t_q <= eval_time_i;
    end
    if (chk) begin
      last_val_q <= ent.value;
      if (ent.key_time <= t_q) begin
        lo_time_q <= ent.key_time;
        lo_val_q  <= ent.value;
        lo_out_q  <= ent.out_slope;
      end
      if (hit) begin
        hi_time_q <= ent.key_time;
        hi_val_q  <= ent.value;
        hi_in_q   <= ent.in_slope;
      end
    end
  end

  assign stat_o.scan_done = have_hi_q || (!chk_vld_q && (rd_idx_q == n_q));
  assign stat_o.interp    = have_hi_q && have_lo_q && !exact_q;

  // restoring divider, u = floor(a * 2^16 / d), one quotient bit per cycle
  logic [KT_W-1:0] rem_q;
  logic [KT_W-1:0] d_q;
  logic [KT_W-1:0] u_q;
  logic [KT_W:0]   rem2;
  logic            ge;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= t_q - lo_time_q;
      d_q   <= hi_time_q - lo_time_q;
      u_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? KT_W'(rem2 - {1'b0, d_q}) : rem2[KT_W-1:0];
      u_q   <= {u_q[KT_W-2:0], ge};
    end
  end

  // shared multiplier with registered product
  logic signed [32:0] op_a;
  logic signed [18:0] op_b;
  logic signed [51:0] prod_q;
  logic        [15:0] u2_q;
  logic        [15:0] u3_q;
  logic signed [47:0] m0_q;
  logic signed [47:0] m1_q;
  logic signed [18:0] h00_q;
  logic signed [18:0] h01_q;
  logic signed [18:0] h10_q;
  logic signed [18:0] h11_q;
  logic signed [18:0] us;
  logic signed [18:0] u2s;
  logic signed [18:0] u3s;
  logic signed [65:0] acc_q;
  logic signed [65:0] prod_ext;

  assign us  = $signed({3'b000, u_q});
  assign u2s = $signed({3'b000, u2_q});
  assign u3s = $signed({3'b000, u3_q});

  // operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.op.mul_sel)
      MUL_UU: begin
        op_a = $signed({17'd0, u_q});
        op_b = us;
      end
      MUL_U2U: begin
        op_a = $signed({17'd0, u2_q});
        op_b = us;
      end
      MUL_OUT0D: begin
        op_a = $signed({lo_out_q[31], lo_out_q});
        op_b = $signed({3'b000, d_q});
      end
      MUL_IN1D: begin
        op_a = $signed({hi_in_q[31], hi_in_q});
        op_b = $signed({3'b000, d_q});
      end
      MUL_H00V0: begin
        op_a = $signed({lo_val_q[31], lo_val_q});
        op_b = h00_q;
      end
      MUL_H01V1: begin
        op_a = $signed({hi_val_q[31], hi_val_q});
        op_b = h01_q;
      end
      MUL_H10M0L: begin
        op_a = $signed({9'd0, m0_q[23:0]});
        op_b = h10_q;
      end
      MUL_H10M0H: begin
        op_a = $signed({{9{m0_q[47]}}, m0_q[47:24]});
        op_b = h10_q;
      end
      MUL_H11M1L: begin
        op_a = $signed({9'd0, m1_q[23:0]});
        op_b = h11_q;
      end
      MUL_H11M1H: begin
        op_a = $signed({{9{m1_q[47]}}, m1_q[47:24]});
        op_b = h11_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_ext = $signed({{14{prod_q[51]}}, prod_q});

  // product register and write back
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (cmd_i.op.wb_sel)
      WB_U2: u2_q <= prod_q[31:16];
      WB_U3: u3_q <= prod_q[31:16];
      WB_M0: m0_q <= prod_q[47:0];
      WB_M1: m1_q <= prod_q[47:0];
      WB_H: begin
        h00_q <= (u3s <<< 1) - (u2s + (u2s <<< 1)) + 19'sd65536;
        h10_q <= u3s - (u2s <<< 1) + us;
        h01_q <= (u2s + (u2s <<< 1)) - (u3s <<< 1);
        h11_q <= u3s - u2s;
        acc_q <= '0;
      end
      WB_ADD0:  acc_q <= acc_q + prod_ext;
      WB_ADD24: acc_q <= acc_q + (prod_ext <<< 24);
      default: begin
      end
    endcase
  end

  // round half up, drop 16 fraction bits, saturate
  logic signed [65:0] rnd;
  logic signed [65:0] shr;
  logic        [31:0] sat;

  assign rnd = acc_q + 66'sd32768;
  assign shr = rnd >>> 16;

  always_comb begin
    if (shr > 66'sd2147483647) begin
      sat = 32'h7fff_ffff;
    end else if (shr < -66'sd2147483648) begin
      sat = 32'h8000_0000;
    end else begin
      sat = shr[31:0];
    end
  end

  // result register
  logic [KV_W-1:0] curve_value_q;
  logic [1:0]      status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      if (n_q == '0) begin
        curve_value_q <= '0;
        status_q      <= STATUS_EMPTY;
      end else if (!have_hi_q) begin
        curve_value_q <= last_val_q;
        status_q      <= STATUS_HELD;
      end else if (!stat_o.interp) begin
        curve_value_q <= hi_val_q;
        status_q      <= STATUS_HELD;
      end else begin
        curve_value_q <= sat;
        status_q      <= STATUS_INTERP;
      end
    end
  end

  assign curve_value_o = curve_value_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

/* rtl/kfh_ctrl.sv */
// controller: sequences search, division and arithmetic steps for one item
// depends on kfh_pkg and the assertion macro header
`default_nettype none
`include "keyframe_hermite_curve_eval_unit_defines.svh"

module kfh_ctrl
  import kfh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      mode_i,
  input  wire kfh_stat_t stat_i,
  output kfh_cmd_t       cmd_o,
  output logic           busy,
  output logic           done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_ARITH,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic              accept;
  logic              div_end;

  assign accept  = start && (state_q == ST_IDLE);
  assign div_end = (state_q == ST_DIV) && (step_q == DIV_LAST);

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = '{mul_sel: MUL_NONE, wb_sel: WB_NONE};
    cmd_o.load      = accept && !mode_i;
    cmd_o.scan_init = accept && mode_i;
    case (state_q)
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.div_init = stat_i.scan_done && stat_i.interp;
      end
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_ARITH: cmd_o.op = arith_cmd(step_q);
      ST_FIN:   cmd_o.res_ld = 1'b1;
      default: begin
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && mode_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat_i.scan_done) begin
            step_q  <= '0;
            state_q <= stat_i.interp ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == DIV_LAST) begin
            step_q  <= '0;
            state_q <= ST_ARITH;
          end
        end
        ST_ARITH: begin
          step_q <= step_q + 1'b1;
          if (step_q == ARITH_LAST) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  // checks
  `KFH_ASSERT_NEXT(a_fin_strobe, state_q == ST_FIN, done_q, "no strobe after finish")
  `KFH_ASSERT_NOW(a_done_idle, done_q, state_q == ST_IDLE, "result shown while busy")
  `KFH_ASSERT_NEXT(a_div_len, div_end, state_q == ST_ARITH, "divider overran")
  `KFH_ASSERT_NEXT(a_eval_start, accept && mode_i, state_q == ST_SCAN, "no search started")
  `KFH_ASSERT_NEXT(a_load_quiet, accept && !mode_i, !done_q && (state_q == ST_IDLE), "load busy")

endmodule

`default_nettype wire

/* rtl/keyframe_hermite_curve_eval_unit.sv */
// top level of the keyframe cubic hermite curve evaluator
// depends on kfh_pkg, kfh_ctrl, kfh_dpath and kfh_ram
//
// usage:
//  - an item is taken when start is high and busy is low; mode_i selects load or evaluate
//  - a load item writes one keyframe into slot key_index_i, if below MAX_KEYS, gives no
//    result, and leaves busy low, so items may follow every cycle
//  - an evaluate item raises busy; the bracket search reads one key per cycle from the
//    key table memory; for an interpolated result a 16-step radix-2 divider then forms the
//    normalized time and 13 steps of one shared multiplier build the hermite sum
//  - an evaluate item ends with an empty, held or interpolated result; done_o is high for
//    one cycle
//  - the result ports hold until the next result; the receiver cannot stall, so every
//    done_o cycle delivers one item and a new item may be started in that same cycle
//  - key_count is written by the user through cfg_we_i and cfg_data_i only while the block is idle; not enforced
//  - reset clears key_count and the controller; table contents are undefined until loaded
`default_nettype none

module keyframe_hermite_curve_eval_unit
  import kfh_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [KC_W-1:0] cfg_data_i,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            mode_i,
  input  wire logic [4:0]      key_index_i,
  input  wire logic [KT_W-1:0] key_time_i,
  input  wire logic [KV_W-1:0] key_value_i,
  input  wire logic [KV_W-1:0] key_in_tangent_i,
  input  wire logic [KV_W-1:0] key_out_tangent_i,
  input  wire logic [KT_W-1:0] eval_time_i,
  output logic                 done_o,
  output logic [KV_W-1:0]      curve_value_o,
  output logic [1:0]           status_o
);

  kfh_cmd_t  cmd;
  kfh_stat_t stat;

  // sequencer
  kfh_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .mode_i(mode_i),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy  (busy),
    .done_o(done_o)
  );

  // table, search and arithmetic
  kfh_dpath #(
    .MAX_KEYS(MAX_KEYS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .key_index_i      (key_index_i),
    .key_time_i       (key_time_i),
    .key_value_i      (key_value_i),
    .key_in_tangent_i (key_in_tangent_i),
    .key_out_tangent_i(key_out_tangent_i),
    .eval_time_i      (eval_time_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .curve_value_o    (curve_value_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire
